@@ rtl/bps_pkg.sv @@
// Shared types, constants and tables of the ballistic pitch solver.
package bps_pkg;

  localparam int ANGLE_FRAC_BITS = 14;
  localparam int CORDIC_STAGES   = 16;
  localparam int PITCH_SH        = 30 - ANGLE_FRAC_BITS;

  localparam logic [19:0] GRAVITY_RESET = 20'd641158;
  localparam logic [10:0] SPEED_SCALE   = 11'd2000;
  localparam logic [17:0] TIME_SCALE    = 18'd256000;
  localparam logic [23:0] TIME_MAX      = 24'hFFFFFF;

  // Square root cells: radicand, root and remainder widths.
  localparam int DELTA_W     = 120;
  localparam int ROOT_W      = 60;
  localparam int SQREM_W     = 64;
  localparam int DELTA_STEPS = 60;
  localparam int MAG_STEPS   = 29;

  // CORDIC datapath widths.
  localparam int CRD_W = 34;
  localparam int ANG_W = 33;

  // Divider cells.
  localparam int DIV_STEPS = 24;
  localparam int DIVREM_W  = 64;
  localparam int DIVDEN_W  = 68;

  typedef struct packed {
    logic [15:0]        muzzle_speed;
    logic [15:0]        horiz_distance;
    logic signed [15:0] rel_height;
  } item_t;

  typedef struct packed {
    logic               no_solution;
    logic signed [15:0] pitch_angle;
    logic [23:0]        flight_time;
  } result_t;

  // atan(2^-i) in Q30 radians, rounded down.
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 33'sd843314856;
      5'd1:    r = 33'sd497837829;
      5'd2:    r = 33'sd263043836;
      5'd3:    r = 33'sd133525158;
      5'd4:    r = 33'sd67021686;
      5'd5:    r = 33'sd33543515;
      5'd6:    r = 33'sd16775850;
      5'd7:    r = 33'sd8388437;
      5'd8:    r = 33'sd4194282;
      5'd9:    r = 33'sd2097149;
      5'd10:   r = 33'sd1048575;
      5'd11:   r = 33'sd524287;
      5'd12:   r = 33'sd262143;
      5'd13:   r = 33'sd131071;
      5'd14:   r = 33'sd65535;
      5'd15:   r = 33'sd32767;
      5'd16:   r = 33'sd16383;
      5'd17:   r = 33'sd8191;
      5'd18:   r = 33'sd4095;
      5'd19:   r = 33'sd2047;
      5'd20:   r = 33'sd1023;
      5'd21:   r = 33'sd511;
      5'd22:   r = 33'sd255;
      5'd23:   r = 33'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Side data traveling with the discriminant square root.
  typedef struct packed {
    logic        vld;
    logic        nosol;
    logic [15:0] d;
    logic [15:0] v;
    logic [58:0] b;
    logic        cneg;
    logic [59:0] cmag;
  } sq_sb_t;

  // Side data traveling with the CORDIC.
  typedef struct packed {
    logic        vld;
    logic        nosol;
    logic [15:0] d;
    logic [15:0] v;
    logic [27:0] xn;
    logic [27:0] yn;
  } cd_sb_t;

  // Side data traveling with the magnitude square root.
  typedef struct packed {
    logic               vld;
    logic               nosol;
    logic [15:0]        d;
    logic signed [15:0] pitch;
    logic [43:0]        den;
  } mg_sb_t;

  // Side data traveling with the divider.
  typedef struct packed {
    logic               vld;
    logic               nosol;
    logic signed [15:0] pitch;
    logic               sat;
  } dv_sb_t;

endpackage

@@ rtl/bps_sqrt_cell.sv @@
// One cell of the digit-by-digit square root: two radicand bits per cell.
module bps_sqrt_cell import bps_pkg::*; (
  input  logic               clk_i,
  input  logic [DELTA_W-1:0] rad_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  logic [SQREM_W-1:0] rem_i,
  output logic [DELTA_W-1:0] rad_o,
  output logic [ROOT_W-1:0]  root_o,
  output logic [SQREM_W-1:0] rem_o
);

  logic [DELTA_W-1:0] rad_d, rad_q;
  logic [ROOT_W-1:0]  root_d, root_q;
  logic [SQREM_W-1:0] rem_d, rem_q, rem_sh, trial;

  always_comb begin
    rem_sh = {rem_i[SQREM_W-3:0], rad_i[DELTA_W-1 -: 2]};
    trial  = {{(SQREM_W-ROOT_W-2){1'b0}}, root_i, 2'b01};
    rad_d  = {rad_i[DELTA_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign rad_o  = rad_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/bps_cordic_cell.sv @@
// One CORDIC vectoring cell: rotates toward the x axis and accumulates the angle.
module bps_cordic_cell import bps_pkg::*; (
  input  logic                    clk_i,
  input  logic [4:0]              stage_i,
  input  logic signed [CRD_W-1:0] x_i,
  input  logic signed [CRD_W-1:0] y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic signed [CRD_W-1:0] x_o,
  output logic signed [CRD_W-1:0] y_o,
  output logic signed [ANG_W-1:0] z_o
);

  logic signed [CRD_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ANG_W-1:0] z_d, z_q;

  always_comb begin
    // Arithmetic shifts floor toward minus infinity, as the angle math expects.
    dx = y_i >>> stage_i;
    dy = x_i >>> stage_i;
    if (!y_i[CRD_W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_q30(stage_i);
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_q30(stage_i);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

@@ rtl/bps_div_cell.sv @@
// One restoring divider cell: produces one quotient bit per cell.
module bps_div_cell import bps_pkg::*; (
  input  logic                clk_i,
  input  logic [DIVREM_W-1:0] rem_i,
  input  logic [DIVDEN_W-1:0] den_i,
  input  logic [23:0]         quot_i,
  output logic [DIVREM_W-1:0] rem_o,
  output logic [DIVDEN_W-1:0] den_o,
  output logic [23:0]         quot_o
);

  logic [DIVREM_W-1:0] rem_d, rem_q;
  logic [DIVDEN_W-1:0] den_d, den_q;
  logic [23:0]         quot_d, quot_q;
  logic                take;

  always_comb begin
    take   = {{(DIVDEN_W-DIVREM_W){1'b0}}, rem_i} >= den_i;
    rem_d  = take ? rem_i - den_i[DIVREM_W-1:0] : rem_i;
    quot_d = {quot_i[22:0], take};
    den_d  = den_i >> 1;
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/ballistic_pitch_solver.sv @@
// Top level of the ballistic pitch solver: fully pipelined chain of arithmetic cells.
//
// The solver takes one shot per clock cycle and never raises busy. Every
// transaction yields exactly one result, strobed on result_valid_o for one
// cycle once the shot has passed through the whole pipeline; results leave
// in order. The pipeline is made up of the cell chains: 60 discriminant
// square root cells, 16 CORDIC cells, 29 magnitude square root cells and 24
// divider cells, plus the multiplier and normalizer stages between them. The
// receiver cannot stall the solver. Write gravity only while no shot is in flight.
module ballistic_pitch_solver import bps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  logic [19:0] grav_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GRAVITY_RESET;
    end else if (cfg_we_i) begin
      grav_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // Front end: exact integer coefficients of the scaled quadratic.
  logic        s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q;
  item_t       s1_item_q, s2_item_q, s3_item_q;
  logic [31:0] s2_d2_q, s2_v2_q;
  logic [51:0] s3_a_q, s4_a_q, s5_a_q;
  logic [42:0] s3_k_q;
  logic [58:0] s4_b_q, s5_b_q, s6_b_q, s7_b_q;
  logic signed [59:0] s4_kh_q;
  logic [15:0] s4_d_q, s5_d_q, s6_d_q, s7_d_q;
  logic [15:0] s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic        s4_deg_q, s5_deg_q, s6_deg_q, s7_deg_q;
  logic        s5_cneg_q, s6_cneg_q, s7_cneg_q;
  logic [59:0] s5_cmag_q, s6_cmag_q, s7_cmag_q;
  logic [57:0] s6_hh_q;
  logic [58:0] s6_hl_q;
  logic [59:0] s6_ll_q;
  logic [53:0] s6_p11_q, s6_p10_q;
  logic [59:0] s6_p01_q, s6_p00_q;
  logic [DELTA_W-1:0] s7_bsq_q, s7_p_q, s8_delta_q;

  logic signed [60:0] c_val, c_abs;
  logic [53:0]        a4;

  assign c_val = $signed({9'b0, s4_a_q}) + s4_kh_q;
  assign c_abs = c_val[60] ? -c_val : c_val;
  assign a4    = {s5_a_q, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_i;
    s2_item_q <= s1_item_q;
    s2_d2_q   <= s1_item_q.horiz_distance * s1_item_q.horiz_distance;
    s2_v2_q   <= s1_item_q.muzzle_speed * s1_item_q.muzzle_speed;
    s3_item_q <= s2_item_q;
    s3_a_q    <= grav_q * s2_d2_q;
    s3_k_q    <= s2_v2_q * SPEED_SCALE;
    s4_b_q    <= s3_k_q * s3_item_q.horiz_distance;
    s4_kh_q   <= $signed({1'b0, s3_k_q}) * s3_item_q.rel_height;
    s4_a_q    <= s3_a_q;
    s4_d_q    <= s3_item_q.horiz_distance;
    s4_v_q    <= s3_item_q.muzzle_speed;
    s4_deg_q  <= (s3_item_q.horiz_distance == 16'd0) || (s3_item_q.muzzle_speed == 16'd0);
    s5_cneg_q <= c_val[60];
    s5_cmag_q <= c_abs[59:0];
    s5_a_q    <= s4_a_q;
    s5_b_q    <= s4_b_q;
    s5_d_q    <= s4_d_q;
    s5_v_q    <= s4_v_q;
    s5_deg_q  <= s4_deg_q;
    // Wide products split into partial products of at most 30 by 30 bits.
    s6_hh_q   <= s5_b_q[58:30] * s5_b_q[58:30];
    s6_hl_q   <= s5_b_q[58:30] * s5_b_q[29:0];
    s6_ll_q   <= s5_b_q[29:0] * s5_b_q[29:0];
    s6_p11_q  <= a4[53:30] * s5_cmag_q[59:30];
    s6_p10_q  <= a4[53:30] * s5_cmag_q[29:0];
    s6_p01_q  <= a4[29:0] * s5_cmag_q[59:30];
    s6_p00_q  <= a4[29:0] * s5_cmag_q[29:0];
    s6_cneg_q <= s5_cneg_q;
    s6_cmag_q <= s5_cmag_q;
    s6_b_q    <= s5_b_q;
    s6_d_q    <= s5_d_q;
    s6_v_q    <= s5_v_q;
    s6_deg_q  <= s5_deg_q;
    s7_bsq_q  <= ({62'b0, s6_hh_q} << 60) + ({61'b0, s6_hl_q} << 31) + {60'b0, s6_ll_q};
    s7_p_q    <= ({66'b0, s6_p11_q} << 60)
               + (({66'b0, s6_p10_q} + {60'b0, s6_p01_q}) << 30) + {60'b0, s6_p00_q};
    s7_cneg_q <= s6_cneg_q;
    s7_cmag_q <= s6_cmag_q;
    s7_b_q    <= s6_b_q;
    s7_d_q    <= s6_d_q;
    s7_v_q    <= s6_v_q;
    s7_deg_q  <= s6_deg_q;
    s8_delta_q <= s7_cneg_q ? s7_bsq_q + s7_p_q : s7_bsq_q - s7_p_q;
  end

  // Discriminant square root chain.
  logic [DELTA_W-1:0] sq_rad  [0:DELTA_STEPS];
  logic [ROOT_W-1:0]  sq_root [0:DELTA_STEPS];
  logic [SQREM_W-1:0] sq_rem  [0:DELTA_STEPS];
  sq_sb_t             sq_sb_q [0:DELTA_STEPS];

  assign sq_rad[0]  = s8_delta_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_sb_q[0] <= '0;
    end else begin
      sq_sb_q[0].vld   <= s7_vld_q;
      sq_sb_q[0].nosol <= s7_deg_q || (!s7_cneg_q && (s7_bsq_q < s7_p_q));
      sq_sb_q[0].d     <= s7_d_q;
      sq_sb_q[0].v     <= s7_v_q;
      sq_sb_q[0].b     <= s7_b_q;
      sq_sb_q[0].cneg  <= s7_cneg_q;
      sq_sb_q[0].cmag  <= s7_cmag_q;
    end
  end

  for (genvar k = 0; k < DELTA_STEPS; k++) begin : g_sq
    bps_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rad_i  (sq_rad[k]),
      .root_i (sq_root[k]),
      .rem_i  (sq_rem[k]),
      .rad_o  (sq_rad[k+1]),
      .root_o (sq_root[k+1]),
      .rem_o  (sq_rem[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_sb_q[k+1] <= '0;
      end else begin
        sq_sb_q[k+1] <= sq_sb_q[k];
      end
    end
  end

  // Root vector and its normalization into [2^27, 2^28).
  sq_sb_t      s9_sb_q, s10_sb_q;
  logic [60:0] s9_x_q, s9_y_q, s10_x_q, s10_y_q;
  logic [5:0]  s10_pos_q;
  logic [60:0] xy_or;
  logic [5:0]  msb_pos;
  logic [27:0] xn_d, yn_d;
  logic [27:0] s11_xn_q, s11_yn_q;
  cd_sb_t      s11_sb_q;
  logic        s11_cneg_q;

  assign xy_or = s9_x_q | s9_y_q;

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < 61; i++) begin
      if (xy_or[i]) begin
        msb_pos = 6'(i);
      end
    end
  end

  always_comb begin
    if (s10_pos_q >= 6'd27) begin
      xn_d = 28'(s10_x_q >> (s10_pos_q - 6'd27));
      yn_d = 28'(s10_y_q >> (s10_pos_q - 6'd27));
    end else begin
      xn_d = 28'(s10_x_q << (6'd27 - s10_pos_q));
      yn_d = 28'(s10_y_q << (6'd27 - s10_pos_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_sb_q  <= '0;
      s10_sb_q <= '0;
      s11_sb_q <= '0;
    end else begin
      s9_sb_q        <= sq_sb_q[DELTA_STEPS];
      s10_sb_q       <= s9_sb_q;
      s11_sb_q.vld   <= s10_sb_q.vld;
      s11_sb_q.nosol <= s10_sb_q.nosol;
      s11_sb_q.d     <= s10_sb_q.d;
      s11_sb_q.v     <= s10_sb_q.v;
      s11_sb_q.xn    <= xn_d;
      s11_sb_q.yn    <= yn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_x_q     <= {2'b00, sq_sb_q[DELTA_STEPS].b} + {1'b0, sq_root[DELTA_STEPS]};
    s9_y_q     <= {sq_sb_q[DELTA_STEPS].cmag, 1'b0};
    s10_x_q    <= s9_x_q;
    s10_y_q    <= s9_y_q;
    s10_pos_q  <= msb_pos;
    s11_xn_q   <= xn_d;
    s11_yn_q   <= yn_d;
    s11_cneg_q <= s10_sb_q.cneg;
  end

  // CORDIC chain.
  logic signed [CRD_W-1:0] crd_x [0:CORDIC_STAGES];
  logic signed [CRD_W-1:0] crd_y [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0] crd_z [0:CORDIC_STAGES];
  cd_sb_t                  cd_sb_q [1:CORDIC_STAGES];
  logic signed [CRD_W-1:0] x_init;

  assign x_init   = $signed({{(CRD_W-28){1'b0}}, s11_xn_q});
  assign crd_x[0] = x_init;
  assign crd_y[0] = s11_cneg_q ? -$signed({{(CRD_W-28){1'b0}}, s11_yn_q})
                               : $signed({{(CRD_W-28){1'b0}}, s11_yn_q});
  assign crd_z[0] = '0;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_crd
    bps_cordic_cell u_cell (
      .clk_i   (clk_i),
      .stage_i (5'(k)),
      .x_i     (crd_x[k]),
      .y_i     (crd_y[k]),
      .z_i     (crd_z[k]),
      .x_o     (crd_x[k+1]),
      .y_o     (crd_y[k+1]),
      .z_o     (crd_z[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cd_sb_q[k+1] <= '0;
      end else if (k == 0) begin
        cd_sb_q[k+1] <= s11_sb_q;
      end else begin
        cd_sb_q[k+1] <= cd_sb_q[(k == 0) ? 1 : k];
      end
    end
  end

  // Pitch rounding, magnitude squares and the time denominator.
  localparam logic signed [ANG_W:0] ROUND_HALF = (ANG_W+1)'(1) << (PITCH_SH - 1);

  logic signed [ANG_W:0] z_round;
  logic signed [15:0]    pitch_d;
  cd_sb_t                cd_last;

  assign cd_last = cd_sb_q[CORDIC_STAGES];
  assign z_round = ($signed({crd_z[CORDIC_STAGES][ANG_W-1], crd_z[CORDIC_STAGES]})
                   + ROUND_HALF) >>> PITCH_SH;

  always_comb begin
    if (z_round > (ANG_W+1)'(32767)) begin
      pitch_d = 16'sh7FFF;
    end else if (z_round < -(ANG_W+1)'(32768)) begin
      pitch_d = 16'sh8000;
    end else begin
      pitch_d = z_round[15:0];
    end
  end

  logic               s12_vld_q, s12_nosol_q;
  logic [15:0]        s12_d_q;
  logic signed [15:0] s12_pitch_q;
  logic [55:0]        s12_xx_q, s12_yy_q;
  logic [43:0]        s12_den_q;
  logic [56:0]        s13_rsq_q;
  mg_sb_t             mg_sb_q [0:MAG_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_vld_q  <= 1'b0;
      mg_sb_q[0] <= '0;
    end else begin
      s12_vld_q        <= cd_last.vld;
      mg_sb_q[0].vld   <= s12_vld_q;
      mg_sb_q[0].nosol <= s12_nosol_q;
      mg_sb_q[0].d     <= s12_d_q;
      mg_sb_q[0].pitch <= s12_pitch_q;
      mg_sb_q[0].den   <= s12_den_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s12_nosol_q <= cd_last.nosol;
    s12_d_q     <= cd_last.d;
    s12_pitch_q <= pitch_d;
    s12_xx_q    <= cd_last.xn * cd_last.xn;
    s12_yy_q    <= cd_last.yn * cd_last.yn;
    s12_den_q   <= cd_last.v * cd_last.xn;
    s13_rsq_q   <= {1'b0, s12_xx_q} + {1'b0, s12_yy_q};
  end

  // Magnitude square root chain, radicand left aligned.
  logic [DELTA_W-1:0] mg_rad  [0:MAG_STEPS];
  logic [ROOT_W-1:0]  mg_root [0:MAG_STEPS];
  logic [SQREM_W-1:0] mg_rem  [0:MAG_STEPS];

  assign mg_rad[0]  = {1'b0, s13_rsq_q, {(DELTA_W-58){1'b0}}};
  assign mg_root[0] = '0;
  assign mg_rem[0]  = '0;

  for (genvar k = 0; k < MAG_STEPS; k++) begin : g_mg
    bps_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rad_i  (mg_rad[k]),
      .root_i (mg_root[k]),
      .rem_i  (mg_rem[k]),
      .rad_o  (mg_rad[k+1]),
      .root_o (mg_root[k+1]),
      .rem_o  (mg_rem[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mg_sb_q[k+1] <= '0;
      end else begin
        mg_sb_q[k+1] <= mg_sb_q[k];
      end
    end
  end

  // Flight time numerator, rounding and saturation test.
  mg_sb_t             mg_last;
  logic               s14_vld_q, s15_vld_q;
  logic               s14_nosol_q, s15_nosol_q;
  logic signed [15:0] s14_pitch_q, s15_pitch_q;
  logic [43:0]        s14_den_q, s15_den_q;
  logic [44:0]        s14_dr_q;
  logic [62:0]        s15_num_q;
  logic [DIVREM_W-1:0] num_round;
  dv_sb_t             dv_sb_q [0:DIV_STEPS];
  logic [DIVREM_W-1:0] dv_rem  [0:DIV_STEPS];
  logic [DIVDEN_W-1:0] dv_den  [0:DIV_STEPS];
  logic [23:0]         dv_quot [0:DIV_STEPS];
  logic [DIVREM_W-1:0] s16_rem_q;
  logic [DIVDEN_W-1:0] s16_den_q;

  assign mg_last   = mg_sb_q[MAG_STEPS];
  assign num_round = {1'b0, s15_num_q} + {20'b0, (s15_den_q >> 1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s14_vld_q  <= 1'b0;
      s15_vld_q  <= 1'b0;
      dv_sb_q[0] <= '0;
    end else begin
      s14_vld_q        <= mg_last.vld;
      s15_vld_q        <= s14_vld_q;
      dv_sb_q[0].vld   <= s15_vld_q;
      dv_sb_q[0].nosol <= s15_nosol_q;
      dv_sb_q[0].pitch <= s15_pitch_q;
      // A zero denominator also lands here and saturates.
      dv_sb_q[0].sat   <= {4'b0, num_round} >= {s15_den_q, 24'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    s14_nosol_q <= mg_last.nosol;
    s14_pitch_q <= mg_last.pitch;
    s14_den_q   <= mg_last.den;
    s14_dr_q    <= mg_last.d * mg_root[MAG_STEPS][28:0];
    s15_nosol_q <= s14_nosol_q;
    s15_pitch_q <= s14_pitch_q;
    s15_den_q   <= s14_den_q;
    s15_num_q   <= s14_dr_q * TIME_SCALE;
    s16_rem_q   <= num_round;
    s16_den_q   <= {1'b0, s15_den_q, 23'b0};
  end

  assign dv_rem[0]  = s16_rem_q;
  assign dv_den[0]  = s16_den_q;
  assign dv_quot[0] = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
    bps_div_cell u_cell (
      .clk_i  (clk_i),
      .rem_i  (dv_rem[k]),
      .den_i  (dv_den[k]),
      .quot_i (dv_quot[k]),
      .rem_o  (dv_rem[k+1]),
      .den_o  (dv_den[k+1]),
      .quot_o (dv_quot[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_sb_q[k+1] <= '0;
      end else begin
        dv_sb_q[k+1] <= dv_sb_q[k];
      end
    end
  end

  // Result register.
  dv_sb_t  dv_last;
  result_t result_d, result_q;
  logic    result_vld_q;

  assign dv_last = dv_sb_q[DIV_STEPS];

  always_comb begin
    result_d.no_solution = dv_last.nosol;
    result_d.pitch_angle = dv_last.nosol ? 16'sd0 : dv_last.pitch;
    if (dv_last.nosol) begin
      result_d.flight_time = '0;
    end else if (dv_last.sat) begin
      result_d.flight_time = TIME_MAX;
    end else begin
      result_d.flight_time = dv_quot[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_vld_q <= 1'b0;
    end else begin
      result_vld_q <= dv_last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_vld_q;
  assign result_o       = result_q;

endmodule
